/* sv/crfr_pkg.sv */
// ----------------------------------------------------------------------------
// crfr_pkg
// Types, codes and helpers shared by the card reader frame responder.
// ----------------------------------------------------------------------------
`default_nettype none

package crfr_pkg;

   // frame bytes
   localparam logic [7:0] BYTE_SOF       = 8'h02;
   localparam logic [7:0] BYTE_CMD_POLL  = 8'h01;
   localparam logic [7:0] BYTE_CMD_CARD  = 8'h0a;
   localparam logic [7:0] BYTE_ZERO      = 8'h00;
   localparam logic [7:0] BYTE_REPLY_DIR = 8'h01;
   localparam logic [7:0] BYTE_TRAILER   = 8'h18;
   localparam logic [7:0] BYTE_CENT_20   = 8'h20;
   localparam logic [7:0] BYTE_CENT_21   = 8'h21;

   localparam int CardBytes  = 9;
   localparam int ReplyBytes = 13;

   localparam logic [3:0] POS_HDR0      = 4'd0;
   localparam logic [3:0] POS_HDR1      = 4'd1;
   localparam logic [3:0] POS_HDR2      = 4'd2;
   localparam logic [3:0] POS_DATA0     = 4'd3;
   localparam logic [3:0] POS_CARD_CHK  = 4'd12;
   localparam logic [3:0] POS_SAT       = 4'd13;
   localparam logic [3:0] IDX_REPLY_END = 4'(ReplyBytes - 1);
   localparam logic [3:0] IDX_CARD_END  = 4'(CardBytes - 1);
   localparam logic [6:0] YEAR_CENTURY  = 7'd100;

   typedef enum logic [1:0] {
      FK_UNKNOWN,
      FK_POLL,
      FK_CARD,
      FK_BAD
   } frame_kind_type;

   typedef enum logic [1:0] {
      OC_PENDING,
      OC_DONE,
      OC_CHECK
   } outcome_type;

   typedef enum logic [1:0] {
      KIND_REPLY,
      KIND_CARD,
      KIND_STATUS
   } item_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPLY,
      ST_CARD,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic          load;
      logic          step;
      logic          clear_idx;
      item_kind_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic dec_reply;
      logic dec_status;
      logic card_go;
      logic reply_last;
      logic card_last;
   } dp_status_type;

   // binary to bcd for values below 100, quotient by reciprocal 205/2048
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  q;
      logic [6:0]  r;
      prod = {8'd0, v} * 15'd205;
      q    = prod[14:11];
      r    = v - ({3'd0, q} * 7'd10);
      return {q, r[3:0]};
   endfunction

endpackage

`default_nettype wire

/* sv/crfr_ifs.sv */
// ----------------------------------------------------------------------------
// crfr channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface crfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       chunk_end;
   logic [6:0] clock_year;
   logic [3:0] clock_month;
   logic [4:0] clock_day;
   logic [4:0] clock_hour;
   logic [5:0] clock_minute;
   logic [5:0] clock_second;

   modport source (
      output valid, rx_byte, chunk_end, clock_year, clock_month, clock_day,
             clock_hour, clock_minute, clock_second,
      input  ready
   );
   modport sink (
      input  valid, rx_byte, chunk_end, clock_year, clock_month, clock_day,
             clock_hour, clock_minute, clock_second,
      output ready
   );
endinterface

interface crfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] item_kind;
   logic [7:0] payload;
   logic       error_code;
   logic       run_last;

   modport source (
      output valid, item_kind, payload, error_code, run_last,
      input  ready
   );
   modport sink (
      input  valid, item_kind, payload, error_code, run_last,
      output ready
   );
endinterface

`default_nettype wire

/* sv/crfr_dp.sv */
// ----------------------------------------------------------------------------
// crfr_dp
// Frame parser state, card byte store, clock capture and result selection.
// ----------------------------------------------------------------------------
`default_nettype none

module crfr_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire crfr_pkg::dp_cmd_type   cmd,
   output crfr_pkg::dp_status_type     sts,
   input  wire logic [7:0]             rx_byte,
   input  wire logic                   chunk_end,
   input  wire logic [6:0]             clock_year,
   input  wire logic [3:0]             clock_month,
   input  wire logic [4:0]             clock_day,
   input  wire logic [4:0]             clock_hour,
   input  wire logic [5:0]             clock_minute,
   input  wire logic [5:0]             clock_second,
   output logic [7:0]                  payload,
   output logic                        error_code
);

   logic [3:0]               pos_ff, pos_in;
   logic [7:0]               check_ff, check_in;
   crfr_pkg::frame_kind_type kind_ff, kind_in;
   crfr_pkg::outcome_type    outcome_ff, outcome_in;
   logic                     card_go_ff, card_go_in;
   logic                     code_ff, code_in;
   logic [3:0]               idx_ff, idx_in;
   logic [7:0]               card_ff [0:crfr_pkg::CardBytes-1];

   logic [6:0] year_ff;
   logic [3:0] month_ff;
   logic [4:0] day_ff;
   logic [4:0] hour_ff;
   logic [5:0] minute_ff;
   logic [5:0] second_ff;

   logic       active;
   logic       dec_reply, dec_card, card_wr;
   logic [3:0] card_wr_idx;

   // ---- frame decision for the byte on the request port
   always_comb begin
      active     = (outcome_ff == crfr_pkg::OC_PENDING) && (kind_ff != crfr_pkg::FK_BAD);
      kind_in    = kind_ff;
      check_in   = check_ff;
      outcome_in = outcome_ff;
      dec_reply  = 1'b0;
      dec_card   = 1'b0;
      card_wr    = 1'b0;
      if (active) begin
         unique case (pos_ff)
            crfr_pkg::POS_HDR0: begin
               if (rx_byte != crfr_pkg::BYTE_SOF) kind_in = crfr_pkg::FK_BAD;
            end
            crfr_pkg::POS_HDR1: begin
               if (rx_byte == crfr_pkg::BYTE_CMD_POLL) kind_in = crfr_pkg::FK_POLL;
               else if (rx_byte == crfr_pkg::BYTE_CMD_CARD) kind_in = crfr_pkg::FK_CARD;
               else kind_in = crfr_pkg::FK_BAD;
               check_in = rx_byte;
            end
            crfr_pkg::POS_HDR2: begin
               if (rx_byte != crfr_pkg::BYTE_ZERO) kind_in = crfr_pkg::FK_BAD;
               check_in = check_ff ^ rx_byte;
            end
            default: begin
               if (kind_ff == crfr_pkg::FK_POLL) begin
                  if (rx_byte == check_ff) begin
                     dec_reply  = 1'b1;
                     outcome_in = crfr_pkg::OC_DONE;
                  end else begin
                     outcome_in = crfr_pkg::OC_CHECK;
                  end
               end else if (kind_ff == crfr_pkg::FK_CARD) begin
                  if (pos_ff < crfr_pkg::POS_CARD_CHK) begin
                     card_wr  = 1'b1;
                     check_in = check_ff ^ rx_byte;
                  end else if (rx_byte == check_ff) begin
                     dec_reply  = 1'b1;
                     dec_card   = 1'b1;
                     outcome_in = crfr_pkg::OC_DONE;
                  end else begin
                     outcome_in = crfr_pkg::OC_CHECK;
                  end
               end
            end
         endcase
      end
      pos_in = (active && (pos_ff < crfr_pkg::POS_SAT)) ? pos_ff + 4'd1 : pos_ff;
      card_wr_idx = pos_ff - crfr_pkg::POS_DATA0;
      card_go_in  = dec_card;
      code_in     = (outcome_in == crfr_pkg::OC_CHECK);
   end

   always_comb begin
      sts.dec_reply  = dec_reply;
      sts.dec_status = chunk_end && (outcome_in != crfr_pkg::OC_DONE);
      sts.card_go    = card_go_ff;
      sts.reply_last = (idx_ff == crfr_pkg::IDX_REPLY_END);
      sts.card_last  = (idx_ff == crfr_pkg::IDX_CARD_END);
   end

   always_comb begin
      if (cmd.load || cmd.clear_idx) idx_in = 4'd0;
      else if (cmd.step) idx_in = idx_ff + 4'd1;
      else idx_in = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 4'd0;
         check_ff   <= 8'd0;
         kind_ff    <= crfr_pkg::FK_UNKNOWN;
         outcome_ff <= crfr_pkg::OC_PENDING;
         card_go_ff <= 1'b0;
         code_ff    <= 1'b0;
         idx_ff     <= 4'd0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.load) begin
            card_go_ff <= card_go_in;
            code_ff    <= code_in;
            // chunk end starts a fresh chunk
            if (chunk_end) begin
               pos_ff     <= 4'd0;
               check_ff   <= 8'd0;
               kind_ff    <= crfr_pkg::FK_UNKNOWN;
               outcome_ff <= crfr_pkg::OC_PENDING;
            end else begin
               pos_ff     <= pos_in;
               check_ff   <= check_in;
               kind_ff    <= kind_in;
               outcome_ff <= outcome_in;
            end
         end
      end
   end

   // card store and clock capture, no reset
   always_ff @(posedge clock) begin
      if (cmd.load && card_wr) card_ff[card_wr_idx] <= rx_byte;
      if (cmd.load) begin
         year_ff   <= clock_year;
         month_ff  <= clock_month;
         day_ff    <= clock_day;
         hour_ff   <= clock_hour;
         minute_ff <= clock_minute;
         second_ff <= clock_second;
      end
   end

   // ---- reply byte assembly
   logic [7:0] cent_b, yy_b, mo_b, dy_b, hr_b, mi_b, se_b, xor_b, reply_b;
   logic [6:0] yy_bin;

   always_comb begin
      if (year_ff >= crfr_pkg::YEAR_CENTURY) begin
         cent_b = crfr_pkg::BYTE_CENT_21;
         yy_bin = year_ff - crfr_pkg::YEAR_CENTURY;
      end else begin
         cent_b = crfr_pkg::BYTE_CENT_20;
         yy_bin = year_ff;
      end
      yy_b  = crfr_pkg::to_bcd(yy_bin);
      mo_b  = crfr_pkg::to_bcd({3'd0, month_ff});
      dy_b  = crfr_pkg::to_bcd({2'd0, day_ff});
      hr_b  = crfr_pkg::to_bcd({2'd0, hour_ff});
      mi_b  = crfr_pkg::to_bcd({1'd0, minute_ff});
      se_b  = crfr_pkg::to_bcd({1'd0, second_ff});
      xor_b = crfr_pkg::BYTE_CMD_CARD ^ crfr_pkg::BYTE_REPLY_DIR ^ cent_b ^ yy_b ^ mo_b
            ^ dy_b ^ hr_b ^ mi_b ^ se_b ^ crfr_pkg::BYTE_TRAILER ^ crfr_pkg::BYTE_ZERO;
      unique case (idx_ff)
         4'd0:    reply_b = crfr_pkg::BYTE_SOF;
         4'd1:    reply_b = crfr_pkg::BYTE_CMD_CARD;
         4'd2:    reply_b = crfr_pkg::BYTE_REPLY_DIR;
         4'd3:    reply_b = cent_b;
         4'd4:    reply_b = yy_b;
         4'd5:    reply_b = mo_b;
         4'd6:    reply_b = dy_b;
         4'd7:    reply_b = hr_b;
         4'd8:    reply_b = mi_b;
         4'd9:    reply_b = se_b;
         4'd10:   reply_b = crfr_pkg::BYTE_TRAILER;
         4'd11:   reply_b = crfr_pkg::BYTE_ZERO;
         default: reply_b = xor_b;
      endcase
   end

   always_comb begin
      payload    = 8'd0;
      error_code = 1'b0;
      unique case (cmd.sel)
         crfr_pkg::KIND_REPLY:  payload = reply_b;
         crfr_pkg::KIND_CARD:   payload = card_ff[idx_ff];
         crfr_pkg::KIND_STATUS: error_code = code_ff;
         default:               payload = 8'd0;
      endcase
   end

endmodule

`default_nettype wire

/* sv/crfr_ctrl.sv */
// ----------------------------------------------------------------------------
// crfr_ctrl
// Sequencer for accepting bytes and emitting reply, card and status results.
// ----------------------------------------------------------------------------
`default_nettype none

module crfr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         run_last,
   output crfr_pkg::dp_cmd_type         cmd,
   input  wire crfr_pkg::dp_status_type sts
);

   crfr_pkg::state_type state_ff, state_in;
   logic                accept, sent;

   assign accept = req_valid && req_ready;
   assign sent   = rsp_valid && rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         crfr_pkg::ST_IDLE: begin
            if (accept) begin
               if (sts.dec_reply) state_in = crfr_pkg::ST_REPLY;
               else if (sts.dec_status) state_in = crfr_pkg::ST_STATUS;
            end
         end
         crfr_pkg::ST_REPLY: begin
            if (sent && sts.reply_last)
               state_in = sts.card_go ? crfr_pkg::ST_CARD : crfr_pkg::ST_IDLE;
         end
         crfr_pkg::ST_CARD: begin
            if (sent && sts.card_last) state_in = crfr_pkg::ST_IDLE;
         end
         crfr_pkg::ST_STATUS: begin
            if (sent) state_in = crfr_pkg::ST_IDLE;
         end
         default: state_in = crfr_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      run_last      = 1'b0;
      cmd.load      = 1'b0;
      cmd.step      = 1'b0;
      cmd.clear_idx = 1'b0;
      cmd.sel       = crfr_pkg::KIND_REPLY;
      unique case (state_ff)
         crfr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = accept;
         end
         crfr_pkg::ST_REPLY: begin
            rsp_valid     = 1'b1;
            run_last      = sts.reply_last && !sts.card_go;
            cmd.step      = sent && !sts.reply_last;
            cmd.clear_idx = sent && sts.reply_last;
         end
         crfr_pkg::ST_CARD: begin
            rsp_valid     = 1'b1;
            run_last      = sts.card_last;
            cmd.sel       = crfr_pkg::KIND_CARD;
            cmd.step      = sent && !sts.card_last;
            cmd.clear_idx = sent && sts.card_last;
         end
         crfr_pkg::ST_STATUS: begin
            rsp_valid = 1'b1;
            run_last  = 1'b1;
            cmd.sel   = crfr_pkg::KIND_STATUS;
         end
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crfr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* sv/card_reader_frame_responder.sv */
// The first result of an accepted byte is valid in the cycle after the transfer.
// A byte with no result leaves the input ready; a byte with n results (up to 22 for a card
// reply) sends one result per cycle from the single output port, stalled by the sink.
// One byte is in work at a time; the next is taken once its last result is transferred.
// Reset (synchronous): clears the chunk parser and sequencer; card byte store is not
// cleared and is only read after a full card frame has written it.
// ----------------------------------------------------------------------------
// card_reader_frame_responder
// Checks poll and card frames in serial read chunks and emits replies,
// captured card bytes and error status.
// ----------------------------------------------------------------------------
`default_nettype none

module card_reader_frame_responder (
   input wire logic   clock,
   input wire logic   reset,
   crfr_req_if.sink   req_if,
   crfr_rsp_if.source rsp_if
);

   crfr_pkg::dp_cmd_type    cmd;
   crfr_pkg::dp_status_type sts;
   logic                    req_ready;
   logic                    rsp_valid;
   logic                    run_last;
   logic [7:0]              payload;
   logic                    error_code;

   crfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .run_last  (run_last),
      .cmd       (cmd),
      .sts       (sts)
   );

   crfr_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .rx_byte      (req_if.rx_byte),
      .chunk_end    (req_if.chunk_end),
      .clock_year   (req_if.clock_year),
      .clock_month  (req_if.clock_month),
      .clock_day    (req_if.clock_day),
      .clock_hour   (req_if.clock_hour),
      .clock_minute (req_if.clock_minute),
      .clock_second (req_if.clock_second),
      .payload      (payload),
      .error_code   (error_code)
   );

   assign req_if.ready      = req_ready;
   assign rsp_if.valid      = rsp_valid;
   assign rsp_if.item_kind  = cmd.sel;
   assign rsp_if.payload    = payload;
   assign rsp_if.error_code = error_code;
   assign rsp_if.run_last   = run_last;

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the card reader frame responder: serial bytes in
// read chunks go in over the request channel, a frame predictor works out
// the reply, card and status bytes, and every response transfer is compared
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------

module tb;
   import crfr_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int HoldCycles = 300;
   localparam int DrainCycles = 30;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_end;
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } rx_item_type;

   typedef struct {
      item_kind_type kind;
      logic [7:0]    payload;
      logic          error_code;
      logic          run_last;
   } rsp_item_type;

   logic clock;
   logic reset;

   crfr_req_if req_bus ();
   crfr_rsp_if rsp_bus ();

   card_reader_frame_responder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   rx_item_type  rx_byte_q[$];
   rsp_item_type expected_rsp_q[$];
   rx_item_type  on_bus;
   rsp_item_type want;

   // frame tracker state
   logic [3:0]     rx_pos;
   logic [7:0]     rx_chk;
   frame_kind_type rx_fk;
   outcome_type    rx_oc;
   logic [7:0]     card_mem[CardBytes];

   // clock stamp applied to the next queued byte
   logic [6:0] st_year;
   logic [3:0] st_month;
   logic [4:0] st_day;
   logic [4:0] st_hour;
   logic [5:0] st_minute;
   logic [5:0] st_second;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_asked;
   int hold_given;
   int hold_left;
   int cycles;
   int mismatches;
   int bytes_sent;
   int chunks_sent;
   int reply_seen;
   int card_seen;
   int status_seen;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      req_bus.chunk_end = 1'b0;
      req_bus.clock_year = '0;
      req_bus.clock_month = '0;
      req_bus.clock_day = '0;
      req_bus.clock_hour = '0;
      req_bus.clock_minute = '0;
      req_bus.clock_second = '0;
      rsp_bus.ready = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] bin2bcd(input int unsigned v);
      return 8'((((v / 10) % 16) << 4) | (v % 10));
   endfunction

   function automatic void push_expect(input item_kind_type k, input logic [7:0] p,
                                       input logic code);
      rsp_item_type r;
      r.kind = k;
      r.payload = p;
      r.error_code = code;
      r.run_last = 1'b0;
      expected_rsp_q.push_back(r);
   endfunction

   function automatic void expect_reply(input rx_item_type it);
      logic [7:0]  b[ReplyBytes];
      int unsigned yr;
      logic [7:0]  x;
      yr = 2000 + it.year;
      b[0] = BYTE_SOF;
      b[1] = BYTE_CMD_CARD;
      b[2] = BYTE_REPLY_DIR;
      b[3] = bin2bcd((yr / 100) % 100);
      b[4] = bin2bcd(yr % 100);
      b[5] = bin2bcd(it.month);
      b[6] = bin2bcd(it.day);
      b[7] = bin2bcd(it.hour);
      b[8] = bin2bcd(it.minute);
      b[9] = bin2bcd(it.second);
      b[10] = BYTE_TRAILER;
      b[11] = BYTE_ZERO;
      x = '0;
      for (int i = 1; i < ReplyBytes - 1; i++) x ^= b[i];
      b[12] = x;
      for (int i = 0; i < ReplyBytes; i++) push_expect(KIND_REPLY, b[i], 1'b0);
   endfunction

   function automatic void predict_byte(input rx_item_type it);
      int unsigned  start;
      rsp_item_type tail;
      logic [7:0]   b;
      start = expected_rsp_q.size();
      b = it.rx_byte;
      if (rx_oc == OC_PENDING && rx_fk != FK_BAD) begin
         if (rx_pos == POS_HDR0) begin
            if (b != BYTE_SOF) rx_fk = FK_BAD;
         end else if (rx_pos == POS_HDR1) begin
            if (b == BYTE_CMD_POLL) rx_fk = FK_POLL;
            else if (b == BYTE_CMD_CARD) rx_fk = FK_CARD;
            else rx_fk = FK_BAD;
            rx_chk = b;
         end else if (rx_pos == POS_HDR2) begin
            if (b != BYTE_ZERO) rx_fk = FK_BAD;
            rx_chk ^= b;
         end else if (rx_fk == FK_POLL) begin
            if (b == rx_chk) begin
               expect_reply(it);
               rx_oc = OC_DONE;
            end else begin
               rx_oc = OC_CHECK;
            end
         end else if (rx_fk == FK_CARD) begin
            if (rx_pos < POS_CARD_CHK) begin
               card_mem[rx_pos - POS_DATA0] = b;
               rx_chk ^= b;
            end else if (b == rx_chk) begin
               expect_reply(it);
               for (int i = 0; i < CardBytes; i++) push_expect(KIND_CARD, card_mem[i], 1'b0);
               rx_oc = OC_DONE;
            end else begin
               rx_oc = OC_CHECK;
            end
         end
         if (rx_pos < POS_SAT) rx_pos++;
      end
      if (it.chunk_end) begin
         if (rx_oc != OC_DONE) push_expect(KIND_STATUS, 8'h00, rx_oc == OC_CHECK);
         rx_pos = '0;
         rx_chk = '0;
         rx_fk = FK_UNKNOWN;
         rx_oc = OC_PENDING;
      end
      if (expected_rsp_q.size() > start) begin
         tail = expected_rsp_q.pop_back();
         tail.run_last = 1'b1;
         expected_rsp_q.push_back(tail);
      end
   endfunction

   function automatic void check_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $error("%s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
                name, exp_v, exp_v, got_v, got_v);
         mismatches++;
      end
   endfunction

   task automatic push_byte(input logic [7:0] b, input bit last_of_chunk);
      rx_item_type it;
      it.rx_byte = b;
      it.chunk_end = last_of_chunk;
      it.year = st_year;
      it.month = st_month;
      it.day = st_day;
      it.hour = st_hour;
      it.minute = st_minute;
      it.second = st_second;
      rx_byte_q.push_back(it);
   endtask

   task automatic shuffle_stamp();
      if ($urandom_range(9) < 8) begin
         st_year = 7'($urandom_range(99));
         st_month = 4'($urandom_range(12, 1));
         st_day = 5'($urandom_range(31, 1));
         st_hour = 5'($urandom_range(23));
         st_minute = 6'($urandom_range(59));
         st_second = 6'($urandom_range(59));
      end else begin
         st_year = 7'($urandom);
         st_month = 4'($urandom);
         st_day = 5'($urandom);
         st_hour = 5'($urandom);
         st_minute = 6'($urandom);
         st_second = 6'($urandom);
      end
   endtask

   // one read chunk: mostly well-formed frames, the rest broken or noise
   task automatic gen_chunk();
      logic [7:0] fb[$];
      logic [7:0] x;
      int         pick;
      int         cut;
      int         pos;
      pick = $urandom_range(99);
      if (pick < 88) begin
         if ($urandom_range(1) == 0) begin
            fb = {BYTE_SOF, BYTE_CMD_POLL, BYTE_ZERO, BYTE_CMD_POLL};
         end else begin
            fb = {BYTE_SOF, BYTE_CMD_CARD, BYTE_ZERO};
            x = BYTE_CMD_CARD;
            for (int i = 0; i < CardBytes; i++) begin
               case ($urandom_range(9))
                  0: fb.push_back(8'h00);
                  1: fb.push_back(8'hff);
                  default: fb.push_back(8'($urandom));
               endcase
               x ^= fb[$];
            end
            fb.push_back(x);
         end
      end else begin
         cut = $urandom_range(16, 1);
         for (int i = 0; i < cut; i++) fb.push_back(8'($urandom));
      end
      if (pick >= 60 && pick < 70) begin
         fb[fb.size() - 1] ^= 8'($urandom_range(255, 1));
      end else if (pick >= 70 && pick < 80) begin
         pos = $urandom_range(2);
         fb[pos] ^= 8'($urandom_range(255, 1));
      end
      if (pick >= 80 && pick < 88) begin
         cut = $urandom_range(fb.size() - 1, 1);
         while (fb.size() > cut) void'(fb.pop_back());
      end else if (pick < 80 && $urandom_range(1) == 1) begin
         cut = $urandom_range(3, 1);
         for (int i = 0; i < cut; i++) fb.push_back(8'($urandom));
      end
      foreach (fb[i]) begin
         shuffle_stamp();
         push_byte(fb[i], i == fb.size() - 1);
      end
   endtask

   task automatic wait_quiet();
      while (rx_byte_q.size() != 0 || req_bus.valid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_byte(on_bus);
            bytes_sent++;
            if (on_bus.chunk_end) chunks_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (rx_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = rx_byte_q.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.rx_byte <= on_bus.rx_byte;
               req_bus.chunk_end <= on_bus.chunk_end;
               req_bus.clock_year <= on_bus.year;
               req_bus.clock_month <= on_bus.month;
               req_bus.clock_day <= on_bus.day;
               req_bus.clock_hour <= on_bus.hour;
               req_bus.clock_minute <= on_bus.minute;
               req_bus.clock_second <= on_bus.second;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response sink, with an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_given) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= HoldCycles;
         hold_given <= hold_given + 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected transfer: item_kind %0d payload 0x%02h error_code %0d",
                   rsp_bus.item_kind, rsp_bus.payload, rsp_bus.error_code);
            mismatches++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("item_kind", want.kind, rsp_bus.item_kind);
            check_field("payload", want.payload, rsp_bus.payload);
            check_field("error_code", want.error_code, rsp_bus.error_code);
            check_field("run_last", want.run_last, rsp_bus.run_last);
            case (want.kind)
               KIND_REPLY: reply_seen++;
               KIND_CARD: card_seen++;
               default: status_seen++;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [7:0] card_data[CardBytes];
      logic [7:0] x;
      int         idle_set[4];
      int         stall_set[4];
      rx_pos = '0;
      rx_chk = '0;
      rx_fk = FK_UNKNOWN;
      rx_oc = OC_PENDING;
      foreach (card_mem[i]) card_mem[i] = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_asked = 0;
      hold_given = 0;
      hold_left = 0;
      cycles = 0;
      mismatches = 0;
      bytes_sent = 0;
      chunks_sent = 0;
      reply_seen = 0;
      card_seen = 0;
      status_seen = 0;
      idle_set = '{0, 50, 0, 36};
      stall_set = '{0, 0, 50, 36};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // poll ending on the chunk's last byte, clock fields at full width
      st_year = 7'h7f;
      st_month = 4'hf;
      st_day = 5'h1f;
      st_hour = 5'h1f;
      st_minute = 6'h3f;
      st_second = 6'h3f;
      push_byte(BYTE_SOF, 1'b0);
      push_byte(BYTE_CMD_POLL, 1'b0);
      push_byte(BYTE_ZERO, 1'b0);
      push_byte(BYTE_CMD_POLL, 1'b1);

      // card frame with extreme data, clock fields all zero
      st_year = '0;
      st_month = '0;
      st_day = '0;
      st_hour = '0;
      st_minute = '0;
      st_second = '0;
      card_data = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'hfe, 8'h7f, 8'h00};
      push_byte(BYTE_SOF, 1'b0);
      push_byte(BYTE_CMD_CARD, 1'b0);
      push_byte(BYTE_ZERO, 1'b0);
      x = BYTE_CMD_CARD;
      foreach (card_data[i]) begin
         push_byte(card_data[i], 1'b0);
         x ^= card_data[i];
      end
      push_byte(x, 1'b1);

      // poll with a bad check byte, then a byte that must be ignored
      st_year = 7'd99;
      st_month = 4'd12;
      st_day = 5'd31;
      st_hour = 5'd23;
      st_minute = 6'd59;
      st_second = 6'd59;
      push_byte(BYTE_SOF, 1'b0);
      push_byte(BYTE_CMD_POLL, 1'b0);
      push_byte(BYTE_ZERO, 1'b0);
      push_byte(BYTE_ZERO, 1'b0);
      push_byte(BYTE_SOF, 1'b1);

      // short chunk, and a chunk with a wrong start byte
      push_byte(BYTE_SOF, 1'b1);
      push_byte(8'hff, 1'b1);
      wait_quiet();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_set[ph];
         recv_stall_pct = stall_set[ph];
         while (rx_byte_q.size() < 83) gen_chunk();
         // sink holds off while bytes keep coming, so the input backs up
         if (ph == 0) hold_asked++;
         wait_quiet();
      end

      if (expected_rsp_q.size() != 0) begin
         $error("%0d expected results never arrived", expected_rsp_q.size());
         mismatches++;
      end
      $display("sent %0d bytes in %0d read chunks over four handshake mixes",
               bytes_sent, chunks_sent);
      $display("checked %0d reply bytes, %0d card bytes and %0d status items",
               reply_seen, card_seen, status_seen);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
